@@ sv/dual_axis_pid_position_loop_top_defines.svh @@
// Assertion macros shared by the position loop RTL.
`ifndef DUAL_AXIS_PID_POSITION_LOOP_TOP_DEFINES_SVH
`define DUAL_AXIS_PID_POSITION_LOOP_TOP_DEFINES_SVH

// Implication checked in the same cycle.
`define DAPL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define DAPL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/dapl_pkg.sv @@
`default_nettype none
package dapl_pkg;

   localparam int ANGLE_W  = 20;
   localparam int ERR_W    = 21;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 19;
   localparam int DT_W     = 16;
   localparam int INTEG_W  = 48;
   localparam int DUTY_W   = 15;
   localparam int CSR_IDX_W = 3;

   localparam int PWM_PERIOD_DEFAULT = 20000;
   localparam logic [23:0] DUTY_GAIN = 24'd9113777;

   // Register indexes of the control port.
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_A  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_B  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_REACH_TOL = 3'd6;

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET  = 16'd25600;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RESET = 16'd0;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RESET = 16'd2560;
   localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET  = 19'd32768;
   localparam logic [LIMIT_W-1:0] REACH_TOL_RESET  = 19'd1638;

   typedef logic signed [ERR_W-1:0] err_type;

   function automatic logic [ERR_W-1:0] err_mag(input err_type e);
      return e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
   endfunction

endpackage
`default_nettype wire

@@ sv/dual_axis_pid_position_loop_top.sv @@
// Two-axis PID position loop. Each request transaction carries two measured angles
// and the sample interval; one response transaction returns the clamped commands,
// PWM duty counts, direction bits and the reached flag. All arithmetic runs on one
// registered 26x26 multiplier and a restoring divider under a sequencer, one axis
// after the other: a response is ready once both axes are done, and a new request is
// taken only after that response has been issued. The 46 quotient steps of the
// derivative division, per axis, make up most of a transaction's work.
// req_stall stays high while a transaction is in work. Control registers may be
// written at any time the block is idle; csr_ready is always high.
`default_nettype none
`include "dual_axis_pid_position_loop_top_defines.svh"
module dual_axis_pid_position_loop_top
   import dapl_pkg::*;
#(
   parameter int PWM_PERIOD = PWM_PERIOD_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  signed [ANGLE_W-1:0]  req_measured_angle_a,
   input  wire  signed [ANGLE_W-1:0]  req_measured_angle_b,
   input  wire         [DT_W-1:0]     req_interval,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic signed [ANGLE_W-1:0]  rsp_command_a,
   output logic signed [ANGLE_W-1:0]  rsp_command_b,
   output logic        [DUTY_W-1:0]   rsp_duty_a,
   output logic                       rsp_dir_a,
   output logic        [DUTY_W-1:0]   rsp_duty_b,
   output logic                       rsp_dir_b,
   output logic                       rsp_reached,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire         [CSR_IDX_W-1:0] csr_index,
   input  wire         [ANGLE_W-1:0]  csr_data
);

   localparam logic [63:0] DUTY_K  = 64'(PWM_PERIOD) * 64'(DUTY_GAIN);
   localparam logic [21:0] DUTY_KH = DUTY_K[43:22];
   localparam logic [21:0] DUTY_KL = DUTY_K[21:0];
   localparam logic [25:0] PERIOD_W = 26'(PWM_PERIOD);
   localparam int DIV_STEPS = 46;
   localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PREP = 4'd1;
   localparam logic [3:0] S_MI   = 4'd2;
   localparam logic [3:0] S_AI   = 4'd3;
   localparam logic [3:0] S_P    = 4'd4;
   localparam logic [3:0] S_IH   = 4'd5;
   localparam logic [3:0] S_IL   = 4'd6;
   localparam logic [3:0] S_DS   = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_DA   = 4'd9;
   localparam logic [3:0] S_MH   = 4'd10;
   localparam logic [3:0] S_ML   = 4'd11;
   localparam logic [3:0] S_DU   = 4'd12;

   localparam logic signed [48:0] INTEG_MAX = 49'sd140737488355327;
   localparam logic signed [48:0] INTEG_MIN = -49'sd140737488355328;

   // control registers
   logic signed [ANGLE_W-1:0] target_a_ff, target_b_ff;
   logic [GAIN_W-1:0]  kp_ff, ki_ff, kd_ff;
   logic [LIMIT_W-1:0] limit_ff, tol_ff;

   logic [3:0]  state_ff;
   logic        ax_ff;
   logic        first_ff;
   logic [DT_W-1:0] dt_ff;
   err_type     err_a_ff, err_b_ff, prev_a_ff, prev_b_ff;
   logic signed [INTEG_W-1:0] integ_a_ff, integ_b_ff;
   logic signed [51:0] prod_ff;
   logic signed [48:0] sum_ff;
   logic        neg_ff;
   logic [45:0] quo_ff;
   logic [DT_W-1:0] rem_ff;
   logic [5:0]  div_cnt_ff;
   logic signed [ANGLE_W-1:0] cmd_a_ff, cmd_b_ff;
   logic [40:0] dhi_ff;
   logic [DUTY_W-1:0] duty_a_ff;
   logic        reached_ff;
   logic        rsp_valid_ff;

   logic signed [25:0] mul_x, mul_y;
   err_type     err_cur, prev_cur;
   logic signed [INTEG_W-1:0] integ_cur;
   logic signed [ANGLE_W-1:0] cmd_cur;
   logic [LIMIT_W-1:0] cmd_mag;
   logic signed [48:0] integ_sum;
   logic signed [48:0] integ_sat;
   logic [16:0] div_t;
   logic signed [48:0] total;
   logic signed [48:0] lim_s;
   logic signed [48:0] clamped;
   logic [37:0] dnum_mag;
   logic [63:0] dsum;
   logic [25:0] dty;
   logic [DUTY_W-1:0] duty_cur;
   logic        out_free;
   logic        req_take;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign err_cur   = ax_ff ? err_b_ff : err_a_ff;
   assign prev_cur  = ax_ff ? prev_b_ff : prev_a_ff;
   assign integ_cur = ax_ff ? integ_b_ff : integ_a_ff;
   assign cmd_cur   = ax_ff ? cmd_b_ff : cmd_a_ff;
   assign cmd_mag   = LIMIT_W'(err_mag(ERR_W'(cmd_cur)));

   always_comb begin
      mul_x = '0;
      mul_y = '0;
      unique case (state_ff)
         S_MI: begin
            mul_x = 26'(err_cur);
            mul_y = 26'(dt_ff);
         end
         S_AI: begin
            mul_x = 26'(kp_ff);
            mul_y = 26'(err_cur);
         end
         S_P: begin
            mul_x = 26'(ki_ff);
            mul_y = 26'($signed(integ_cur[47:24]));
         end
         S_IH: begin
            mul_x = 26'(ki_ff);
            mul_y = 26'(integ_cur[23:0]);
         end
         S_IL: begin
            mul_x = 26'(kd_ff);
            mul_y = 26'(22'(err_cur) - 22'(prev_cur));
         end
         S_MH: begin
            mul_x = 26'(cmd_mag);
            mul_y = 26'(DUTY_KH);
         end
         S_ML: begin
            mul_x = 26'(cmd_mag);
            mul_y = 26'(DUTY_KL);
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   // The integral sum carries one guard bit so that saturation is exact.
   assign integ_sum = 49'(integ_cur) + 49'(prod_ff);
   always_comb begin
      if (integ_sum > INTEG_MAX) integ_sat = INTEG_MAX;
      else if (integ_sum < INTEG_MIN) integ_sat = INTEG_MIN;
      else integ_sat = integ_sum;
   end

   assign dnum_mag = prod_ff[51] ? 38'(-prod_ff) : prod_ff[37:0];
   assign div_t    = {rem_ff, quo_ff[45]};

   assign total = sum_ff + (neg_ff ? -49'($unsigned(quo_ff)) : 49'($unsigned(quo_ff)));
   assign lim_s = 49'($unsigned(limit_ff));
   always_comb begin
      if (total > lim_s) clamped = lim_s;
      else if (total < -lim_s) clamped = -lim_s;
      else clamped = total;
   end

   assign dsum = {1'b0, dhi_ff, 22'b0} + 64'(prod_ff[40:0]);
   assign dty  = dsum[63:38];
   assign duty_cur = (dty > PERIOD_W) ? PERIOD_W[DUTY_W-1:0] : dty[DUTY_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         target_a_ff <= '0;
         target_b_ff <= '0;
         kp_ff       <= PROP_GAIN_RESET;
         ki_ff       <= INTEG_GAIN_RESET;
         kd_ff       <= DERIV_GAIN_RESET;
         limit_ff    <= OUT_LIMIT_RESET;
         tol_ff      <= REACH_TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TARGET_A:   target_a_ff <= csr_data;
            REG_TARGET_B:   target_b_ff <= csr_data;
            REG_PROP_GAIN:  kp_ff    <= csr_data[GAIN_W-1:0];
            REG_INTEG_GAIN: ki_ff    <= csr_data[GAIN_W-1:0];
            REG_DERIV_GAIN: kd_ff    <= csr_data[GAIN_W-1:0];
            REG_OUT_LIMIT:  limit_ff <= csr_data[LIMIT_W-1:0];
            REG_REACH_TOL:  tol_ff   <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ax_ff        <= 1'b0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         prev_a_ff    <= '0;
         prev_b_ff    <= '0;
         integ_a_ff   <= '0;
         integ_b_ff   <= '0;
         div_cnt_ff   <= '0;
      end else begin
         if (state_ff != S_DU) prod_ff <= mul_x * mul_y;
         if (state_ff == S_DU && ax_ff && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  err_a_ff <= 21'(target_a_ff) - 21'(req_measured_angle_a);
                  err_b_ff <= 21'(target_b_ff) - 21'(req_measured_angle_b);
                  dt_ff    <= (req_interval == '0) ? DT_W'(1) : req_interval;
                  ax_ff    <= 1'b0;
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               if (first_ff) begin
                  prev_a_ff <= err_a_ff;
                  prev_b_ff <= err_b_ff;
                  first_ff  <= 1'b0;
               end
               // On the first sample the current error stands in for the previous one.
               reached_ff <= (err_mag(err_a_ff) < ERR_W'(tol_ff)) &&
                             (err_mag(err_b_ff) < ERR_W'(tol_ff)) &&
                             (err_mag(first_ff ? err_a_ff : prev_a_ff) < ERR_W'(tol_ff)) &&
                             (err_mag(first_ff ? err_b_ff : prev_b_ff) < ERR_W'(tol_ff));
               state_ff <= S_MI;
            end
            S_MI: state_ff <= S_AI;
            S_AI: begin
               if (ax_ff) integ_b_ff <= integ_sat[47:0];
               else integ_a_ff <= integ_sat[47:0];
               state_ff <= S_P;
            end
            S_P: begin
               sum_ff   <= 49'(prod_ff >>> 8);
               state_ff <= S_IH;
            end
            S_IH: begin
               sum_ff   <= sum_ff + 49'(prod_ff);
               state_ff <= S_IL;
            end
            S_IL: begin
               sum_ff   <= sum_ff + 49'(prod_ff[39:24]);
               state_ff <= S_DS;
            end
            S_DS: begin
               neg_ff     <= prod_ff[51];
               quo_ff     <= {dnum_mag, 8'b0};
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               if (ax_ff) prev_b_ff <= err_b_ff;
               else prev_a_ff <= err_a_ff;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_t >= 17'(dt_ff)) begin
                  rem_ff <= DT_W'(div_t - 17'(dt_ff));
                  quo_ff <= {quo_ff[44:0], 1'b1};
               end else begin
                  rem_ff <= div_t[DT_W-1:0];
                  quo_ff <= {quo_ff[44:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == DIV_LAST) state_ff <= S_DA;
            end
            S_DA: begin
               if (ax_ff) cmd_b_ff <= clamped[ANGLE_W-1:0];
               else cmd_a_ff <= clamped[ANGLE_W-1:0];
               state_ff <= S_MH;
            end
            S_MH: state_ff <= S_ML;
            S_ML: begin
               dhi_ff   <= prod_ff[40:0];
               state_ff <= S_DU;
            end
            S_DU: begin
               if (!ax_ff) begin
                  duty_a_ff <= duty_cur;
                  ax_ff     <= 1'b1;
                  state_ff  <= S_MI;
               end else if (out_free) begin
                  // The product register holds still while we wait, so duty_cur is stable.
                  rsp_command_a <= cmd_a_ff;
                  rsp_command_b <= cmd_b_ff;
                  rsp_duty_a    <= duty_a_ff;
                  rsp_dir_a     <= (cmd_a_ff > 0);
                  rsp_duty_b    <= duty_cur;
                  rsp_dir_b     <= (cmd_b_ff > 0);
                  rsp_reached   <= reached_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `DAPL_ASSERT_IMP(a_rem_below_dt, clock, reset, state_ff == S_DIV, rem_ff < dt_ff, "divider remainder not below interval")
   `DAPL_ASSERT_IMP(a_rsp_from_du, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_DU, "response raised outside final step")
   `DAPL_ASSERT_IMP(a_zero_cmd_duty, clock, reset, rsp_valid_ff && rsp_command_a == '0, rsp_duty_a == '0 && !rsp_dir_a, "zero command with non-zero duty")

endmodule
`default_nettype wire
